[design/fcwdm_pkg.sv]
package fcwdm_pkg;

  // Default dictionary depth
  localparam int unsigned DICT_DEPTH_DEFAULT = 4096;

  // Field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned FILL_W  = 3;

  // Characters in one window
  localparam logic [FILL_W-1:0] WORD_LEN = 3'd4;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_STORE = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_EOL   = 2'd2
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic scan_rd;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic addr_last;
    logic scan_needed;
    logic out_free;
  } dp_status_t;

endpackage

[design/four_char_window_dictionary_match.sv]
// Four-character window dictionary match. Store beats write a four-letter
// word into a dictionary slot, character beats shift text into a window,
// and end-of-line beats empty it; every beat gives one result beat. Once a
// line has supplied four characters, each character beat sweeps the whole
// dictionary memory through its single read port, one entry per cycle,
// testing the window and its byte reversal; such a beat passes the scan,
// last and result states, any other beat just the result state. After reset
// the block clears every dictionary entry with in_stall_o high. A finished
// result sits in an output register, so the next beat is taken while it waits.
module four_char_window_dictionary_match
  import fcwdm_pkg::*;
#(
  parameter int unsigned DICT_DEPTH = DICT_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [INDEX_W-1:0] entry_index_i,
  input  logic [WORD_W-1:0]  entry_word_i,
  input  logic [CHAR_W-1:0]  text_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               forward_hit_o,
  output logic               reverse_hit_o,
  output logic [WORD_W-1:0]  window_text_o,
  output logic [WORD_W-1:0]  hit_total_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fcwdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcwdm_datapath #(
    .DICT_DEPTH (DICT_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_word_i  (entry_word_i),
    .text_char_i   (text_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .forward_hit_o (forward_hit_o),
    .reverse_hit_o (reverse_hit_o),
    .window_text_o (window_text_o),
    .hit_total_o   (hit_total_o)
  );

endmodule

[design/fcwdm_ctrl.sv]
module fcwdm_ctrl
  import fcwdm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_LAST   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_q, state_d;

  // Take input beats only when idle
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.scan_needed ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        // let the final read data be compared
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/fcwdm_datapath.sv]
module fcwdm_datapath
  import fcwdm_pkg::*;
#(
  parameter int unsigned DICT_DEPTH = DICT_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [INDEX_W-1:0] entry_index_i,
  input  logic [WORD_W-1:0]  entry_word_i,
  input  logic [CHAR_W-1:0]  text_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               forward_hit_o,
  output logic               reverse_hit_o,
  output logic [WORD_W-1:0]  window_text_o,
  output logic [WORD_W-1:0]  hit_total_o
);

  localparam int unsigned ADDR_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int unsigned EXT_W  = 17;

  // Dictionary memory: valid flag over the word
  logic [WORD_W:0] mem [DICT_DEPTH];

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [WORD_W:0]   rd_q;
  logic              rd_valid_q;
  logic [WORD_W-1:0] window_q, window_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WORD_W-1:0] counter_q;
  logic              fwd_q, rev_q;
  logic              out_valid_q;
  logic              fwd_out_q, rev_out_q;
  logic [WORD_W-1:0] window_out_q, total_out_q;

  logic [EXT_W-1:0]  idx_ext;
  logic              idx_in_range;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [WORD_W:0]   mem_wd;
  logic              addr_last;
  logic [WORD_W-1:0] window_rev;
  logic              hit_fwd, hit_rev;
  logic [WORD_W:0]   total_sum;
  logic [WORD_W-1:0] total_next;
  logic              is_char;

  assign is_char      = (kind_i == KIND_CHAR);
  assign idx_ext      = {{(EXT_W - INDEX_W){1'b0}}, entry_index_i};
  assign idx_in_range = (idx_ext < EXT_W'(DICT_DEPTH));
  assign addr_last    = (addr_q == ADDR_W'(DICT_DEPTH - 1));

  // Status back to the controller
  assign status_o.addr_last   = addr_last;
  assign status_o.scan_needed = is_char && (fill_q >= (WORD_LEN - 3'd1));
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // Sweep address for clearing and scanning
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.accept) begin
      addr_d = '0;
    end else if (cmd_i.clear_wr || cmd_i.scan_rd) begin
      addr_d = addr_last ? '0 : addr_q + ADDR_W'(1);
    end
  end

  // Write port: clearing pass or store beat
  assign mem_we = cmd_i.clear_wr ||
                  (cmd_i.accept && (kind_i == KIND_STORE) && idx_in_range);
  assign mem_wa = cmd_i.clear_wr ? addr_q : idx_ext[ADDR_W-1:0];
  assign mem_wd = cmd_i.clear_wr ? '0 : {1'b1, entry_word_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_q <= mem[addr_q];
    end
  end

  // Window and fill update on an accepted beat
  always_comb begin
    window_d = window_q;
    fill_d   = fill_q;
    if (cmd_i.accept) begin
      if (kind_i == KIND_CHAR) begin
        window_d = {window_q[WORD_W-CHAR_W-1:0], text_char_i};
        if (fill_q < WORD_LEN) begin
          fill_d = fill_q + 3'd1;
        end
      end else if (kind_i == KIND_EOL) begin
        window_d = '0;
        fill_d   = '0;
      end
    end
  end

  // Compare the fetched entry in both orientations
  assign window_rev = {window_q[7:0], window_q[15:8], window_q[23:16], window_q[31:24]};
  assign hit_fwd    = rd_valid_q && rd_q[WORD_W] && (rd_q[WORD_W-1:0] == window_q);
  assign hit_rev    = rd_valid_q && rd_q[WORD_W] && (rd_q[WORD_W-1:0] == window_rev);

  // Saturating add of this beat's hits
  assign total_sum  = {1'b0, counter_q} + {{WORD_W{1'b0}}, fwd_q}
                      + {{WORD_W{1'b0}}, rev_q};
  assign total_next = total_sum[WORD_W] ? '1 : total_sum[WORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_valid_q  <= 1'b0;
      window_q    <= '0;
      fill_q      <= '0;
      counter_q   <= '0;
      fwd_q       <= 1'b0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      addr_q     <= addr_d;
      rd_valid_q <= cmd_i.scan_rd;
      window_q   <= window_d;
      fill_q     <= fill_d;
      // accumulate hits over the sweep
      if (cmd_i.accept) begin
        fwd_q <= 1'b0;
        rev_q <= 1'b0;
      end else begin
        fwd_q <= fwd_q | hit_fwd;
        rev_q <= rev_q | hit_rev;
      end
      if (cmd_i.load_out) begin
        counter_q <= total_next;
      end
      // hold the result beat until taken
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      fwd_out_q    <= fwd_q;
      rev_out_q    <= rev_q;
      window_out_q <= window_q;
      total_out_q  <= total_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign forward_hit_o = fwd_out_q;
  assign reverse_hit_o = rev_out_q;
  assign window_text_o = window_out_q;
  assign hit_total_o   = total_out_q;

endmodule

[design/fcwdm_checker.sv]
module fcwdm_checker
  import fcwdm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [KIND_W-1:0]  kind_i,
  input logic [INDEX_W-1:0] entry_index_i,
  input logic [WORD_W-1:0]  entry_word_i,
  input logic [CHAR_W-1:0]  text_char_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               forward_hit_o,
  input logic               reverse_hit_o,
  input logic [WORD_W-1:0]  window_text_o,
  input logic [WORD_W-1:0]  hit_total_o
);

  // Clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o)
    else $error("input open during reset clearing pass");

  // One item at a time: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input still open after an accepted beat");

  // A stalled input beat holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i &&
      $stable({kind_i, entry_index_i, entry_word_i, text_char_i}))
    else $error("input beat changed while stalled");

  // A reported hit has been counted
  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (forward_hit_o || reverse_hit_o) |-> (hit_total_o != '0))
    else $error("hit reported with zero total");

  // A stalled result beat stays with its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({forward_hit_o, reverse_hit_o, window_text_o, hit_total_o}))
    else $error("result beat dropped or changed while stalled");

endmodule

bind four_char_window_dictionary_match fcwdm_checker u_fcwdm_checker (.*);
